>>> sv/split_direct_mapped_cache_tags_defines.svh
// Assertion helpers for the split direct-mapped cache tag block.
`ifndef SPLIT_DIRECT_MAPPED_CACHE_TAGS_DEFINES_SVH
`define SPLIT_DIRECT_MAPPED_CACHE_TAGS_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SDMCT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdmct assertion failed");

// Next-cycle implication, disabled during reset.
`define SDMCT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdmct assertion failed");

`endif

>>> sv/sdmct_pkg.sv
package sdmct_pkg;

  localparam int ADDR_W     = 32;
  localparam int TAG_W      = 32;
  localparam int LINE_W     = 10;
  localparam int CNT_W      = 32;
  localparam int RATIO_W    = 17;
  localparam int AMAT_W     = 25;
  localparam int IDX_W      = 4;
  localparam int OFF_W      = 5;
  localparam int CYC_W      = 16;
  localparam int FRAC_W     = 8;
  localparam int SHAMT_W    = 6;
  localparam int PROD_W     = CYC_W + RATIO_W;
  localparam int DIV_CNT_W  = $clog2(RATIO_W);
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIT_CYCLES   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_PENALTY = 4'd3;

  // Reset values of the configuration registers
  localparam logic [IDX_W-1:0] RST_INDEX_BITS   = 4'd6;
  localparam logic [OFF_W-1:0] RST_OFFSET_BITS  = 5'd4;
  localparam logic [CYC_W-1:0] RST_HIT_CYCLES   = 16'd1;
  localparam logic [CYC_W-1:0] RST_MISS_PENALTY = 16'd100;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic valid;
    logic [TAG_W-1:0] tag;
  } line_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic lookup;
    logic div_load;
    logic div_step;
    logic mul;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> sv/sdmct_ifs.sv
interface sdmct_req_if;
  logic valid;
  logic ready;
  logic command;
  logic [sdmct_pkg::ADDR_W-1:0] address;

  modport source (output valid, command, address, input ready);
  modport sink (input valid, command, address, output ready);
endinterface

interface sdmct_rsp_if;
  logic valid;
  logic ready;
  logic hit;
  logic [sdmct_pkg::CNT_W-1:0] access_count;
  logic [sdmct_pkg::CNT_W-1:0] hit_count;
  logic [sdmct_pkg::CNT_W-1:0] miss_count;
  logic [sdmct_pkg::RATIO_W-1:0] miss_ratio_q16;
  logic [sdmct_pkg::AMAT_W-1:0] amat_q8;

  modport source (output valid, hit, access_count, hit_count, miss_count, miss_ratio_q16,
                  amat_q8, input ready);
  modport sink (input valid, hit, access_count, hit_count, miss_count, miss_ratio_q16,
                amat_q8, output ready);
endinterface

interface sdmct_cfg_if;
  logic valid;
  logic ready;
  logic [sdmct_pkg::CFG_IDX_W-1:0] index;
  logic [sdmct_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/sdmct_tag_ram.sv
module sdmct_tag_ram #(
  parameter int ADDR_BITS = 10,
  parameter int WIDTH     = 33
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [(1 << ADDR_BITS)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/sdmct_ctrl.sv
module sdmct_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  sdmct_pkg::dp_stat_t stat,
  output sdmct_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CMP,
    S_LOAD,
    S_DIV,
    S_MUL,
    S_FIN
  } state_t;

  state_t state;
  logic [sdmct_pkg::DIV_CNT_W-1:0] div_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      div_cnt <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (stat.clear_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) state <= S_READ;
        end
        S_READ: state <= S_CMP;
        S_CMP:  state <= S_LOAD;
        S_LOAD: begin
          state   <= S_DIV;
          div_cnt <= sdmct_pkg::DIV_CNT_W'(sdmct_pkg::RATIO_W - 1);
        end
        S_DIV: begin
          if (div_cnt == '0) state <= S_MUL;
          else div_cnt <= div_cnt - sdmct_pkg::DIV_CNT_W'(1);
        end
        S_MUL: state <= S_FIN;
        S_FIN: begin
          if (stat.out_free) state <= S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_CLEAR: cmd.clear    = 1'b1;
      S_IDLE:  cmd.capture  = req_valid;
      S_CMP:   cmd.lookup   = 1'b1;
      S_LOAD:  cmd.div_load = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_MUL:   cmd.mul      = 1'b1;
      S_FIN:   cmd.out_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

  assign req_ready = (state == S_IDLE);

endmodule

>>> sv/sdmct_dp.sv
module sdmct_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  sdmct_pkg::dp_cmd_t                  cmd,
  output sdmct_pkg::dp_stat_t                 stat,
  input  logic                                req_command,
  input  logic [sdmct_pkg::ADDR_W-1:0]        req_address,
  input  logic                                cfg_we,
  input  logic [sdmct_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sdmct_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                rsp_ready,
  output logic                                rsp_valid,
  output logic                                rsp_hit,
  output logic [sdmct_pkg::CNT_W-1:0]         rsp_access_count,
  output logic [sdmct_pkg::CNT_W-1:0]         rsp_hit_count,
  output logic [sdmct_pkg::CNT_W-1:0]         rsp_miss_count,
  output logic [sdmct_pkg::RATIO_W-1:0]       rsp_miss_ratio_q16,
  output logic [sdmct_pkg::AMAT_W-1:0]        rsp_amat_q8
);

  localparam int LINE_BITS = $bits(sdmct_pkg::line_t);

  // Configuration registers
  logic [sdmct_pkg::IDX_W-1:0] index_bits;
  logic [sdmct_pkg::OFF_W-1:0] offset_bits;
  logic [sdmct_pkg::CYC_W-1:0] hit_cycles;
  logic [sdmct_pkg::CYC_W-1:0] miss_penalty;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits   <= sdmct_pkg::RST_INDEX_BITS;
      offset_bits  <= sdmct_pkg::RST_OFFSET_BITS;
      hit_cycles   <= sdmct_pkg::RST_HIT_CYCLES;
      miss_penalty <= sdmct_pkg::RST_MISS_PENALTY;
    end else if (cfg_we) begin
      case (cfg_index)
        sdmct_pkg::REG_INDEX_BITS:   index_bits   <= cfg_data[sdmct_pkg::IDX_W-1:0];
        sdmct_pkg::REG_OFFSET_BITS:  offset_bits  <= cfg_data[sdmct_pkg::OFF_W-1:0];
        sdmct_pkg::REG_HIT_CYCLES:   hit_cycles   <= cfg_data[sdmct_pkg::CYC_W-1:0];
        sdmct_pkg::REG_MISS_PENALTY: miss_penalty <= cfg_data[sdmct_pkg::CYC_W-1:0];
        default: ;
      endcase
    end
  end

  // Address split
  logic [sdmct_pkg::ADDR_W-1:0]  shifted;
  logic [sdmct_pkg::LINE_W-1:0]  line_mask;
  logic [sdmct_pkg::SHAMT_W-1:0] tag_shamt;
  logic [sdmct_pkg::LINE_W-1:0]  line_in;
  logic [sdmct_pkg::TAG_W-1:0]   tag_in;

  always_comb begin
    shifted   = req_address >> offset_bits;
    // index widths past LINE_W select all line bits
    line_mask = ~({sdmct_pkg::LINE_W{1'b1}} << index_bits);
    line_in   = shifted[sdmct_pkg::LINE_W-1:0] & line_mask;
    tag_shamt = sdmct_pkg::SHAMT_W'(index_bits) + sdmct_pkg::SHAMT_W'(offset_bits);
    tag_in    = sdmct_pkg::TAG_W'(req_address >> tag_shamt);
  end

  logic                          cmd_sel;
  logic [sdmct_pkg::LINE_W-1:0]  line;
  logic [sdmct_pkg::TAG_W-1:0]   tag;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_sel <= req_command;
      line    <= line_in;
      tag     <= tag_in;
    end
  end

  // Clearing pass pointer
  logic [sdmct_pkg::LINE_W-1:0] clear_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_ptr <= '0;
    end else if (cmd.clear) begin
      clear_ptr <= clear_ptr + sdmct_pkg::LINE_W'(1);
    end
  end

  // Tag stores
  sdmct_pkg::line_t rd_data, rd_instr, rd_sel, wr_line;
  logic [sdmct_pkg::LINE_W-1:0] waddr;
  logic hit_now;
  logic we_data, we_instr;

  always_comb begin
    rd_sel   = cmd_sel ? rd_instr : rd_data;
    hit_now  = rd_sel.valid && (rd_sel.tag == tag);
    waddr    = cmd.clear ? clear_ptr : line;
    wr_line  = cmd.clear ? sdmct_pkg::line_t'('0)
                         : sdmct_pkg::line_t'{valid: 1'b1, tag: tag};
    we_data  = cmd.clear || (cmd.lookup && !hit_now && !cmd_sel);
    we_instr = cmd.clear || (cmd.lookup && !hit_now && cmd_sel);
  end

  sdmct_tag_ram #(
    .ADDR_BITS (sdmct_pkg::LINE_W),
    .WIDTH     (LINE_BITS)
  ) u_data_ram (
    .clk   (clk),
    .we    (we_data),
    .waddr (waddr),
    .wdata (wr_line),
    .raddr (line),
    .rdata (rd_data)
  );

  sdmct_tag_ram #(
    .ADDR_BITS (sdmct_pkg::LINE_W),
    .WIDTH     (LINE_BITS)
  ) u_instr_ram (
    .clk   (clk),
    .we    (we_instr),
    .waddr (waddr),
    .wdata (wr_line),
    .raddr (line),
    .rdata (rd_instr)
  );

  // Saturating counters
  logic                        hit;
  logic [sdmct_pkg::CNT_W-1:0] acc_cnt, hit_cnt, miss_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_cnt  <= '0;
      hit_cnt  <= '0;
      miss_cnt <= '0;
    end else if (cmd.lookup) begin
      if (acc_cnt != sdmct_pkg::CNT_MAX) acc_cnt <= acc_cnt + sdmct_pkg::CNT_W'(1);
      if (hit_now) begin
        if (hit_cnt != sdmct_pkg::CNT_MAX) hit_cnt <= hit_cnt + sdmct_pkg::CNT_W'(1);
      end else begin
        if (miss_cnt != sdmct_pkg::CNT_MAX) miss_cnt <= miss_cnt + sdmct_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) hit <= hit_now;
  end

  // Restoring divider: misses <= accesses, so the partial remainder stays below
  // twice the divisor and one quotient bit falls out per step.
  logic [sdmct_pkg::CNT_W:0]     rem, rem_diff, rem_keep;
  logic [sdmct_pkg::RATIO_W-1:0] quo;
  logic                          rem_ge;

  always_comb begin
    rem_ge   = rem >= {1'b0, acc_cnt};
    rem_diff = rem - {1'b0, acc_cnt};
    rem_keep = rem_ge ? rem_diff : rem;
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem <= {1'b0, miss_cnt};
      quo <= '0;
    end else if (cmd.div_step) begin
      rem <= {rem_keep[sdmct_pkg::CNT_W-1:0], 1'b0};
      quo <= {quo[sdmct_pkg::RATIO_W-2:0], rem_ge};
    end
  end

  // Penalty weighting
  logic [sdmct_pkg::PROD_W-1:0] prod;
  logic [sdmct_pkg::AMAT_W-1:0] amat;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= sdmct_pkg::PROD_W'(miss_penalty) * sdmct_pkg::PROD_W'(quo);
    end
  end

  assign amat = sdmct_pkg::AMAT_W'({hit_cycles, {sdmct_pkg::FRAC_W{1'b0}}})
              + sdmct_pkg::AMAT_W'(prod[sdmct_pkg::PROD_W-1:sdmct_pkg::FRAC_W]);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_hit            <= hit;
      rsp_access_count   <= acc_cnt;
      rsp_hit_count      <= hit_cnt;
      rsp_miss_count     <= miss_cnt;
      rsp_miss_ratio_q16 <= quo;
      rsp_amat_q8        <= amat;
    end
  end

  assign stat.clear_last = (clear_ptr == {sdmct_pkg::LINE_W{1'b1}});
  assign stat.out_free   = !rsp_valid || rsp_ready;

endmodule

>>> sv/split_direct_mapped_cache_tags.sv
// Split direct-mapped cache tag store with separate data and instruction tags.
// req channel: command (0 data, 1 instruction) and a 32-bit byte address.
// rsp channel: hit flag, saturating access/hit/miss counts, miss ratio (Q1.16)
//   and average access time (Q.8) = hit_cycles + miss_penalty * miss ratio.
// cfg channel: register index and write data; always ready. Write only while
//   no transaction is in flight.
// Sequence: after the req transaction the block steps through S_READ, S_CMP,
//   S_LOAD, the 17-step restoring divider for the miss ratio, S_MUL and S_FIN,
//   which loads the output register; req.ready stays low until S_IDLE again.
// Reset: a clearing pass writes every line of both tag RAMs invalid, with
//   req.ready low; cfg writes are taken during the pass.
//   Counters clear and registers return to their defaults.
// Stall: the result sits in an output register, so the next req transaction
//   is still taken; the block waits at the end of that item until rsp.ready.
module split_direct_mapped_cache_tags (
  input logic         clk,
  input logic         rst,
  sdmct_req_if.sink   req,
  sdmct_rsp_if.source rsp,
  sdmct_cfg_if.sink   cfg
);

  sdmct_pkg::dp_cmd_t  cmd;
  sdmct_pkg::dp_stat_t stat;

  assign cfg.ready = 1'b1;

  sdmct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sdmct_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .req_command        (req.command),
    .req_address        (req.address),
    .cfg_we             (cfg.valid && cfg.ready),
    .cfg_index          (cfg.index),
    .cfg_data           (cfg.data),
    .rsp_ready          (rsp.ready),
    .rsp_valid          (rsp.valid),
    .rsp_hit            (rsp.hit),
    .rsp_access_count   (rsp.access_count),
    .rsp_hit_count      (rsp.hit_count),
    .rsp_miss_count     (rsp.miss_count),
    .rsp_miss_ratio_q16 (rsp.miss_ratio_q16),
    .rsp_amat_q8        (rsp.amat_q8)
  );

endmodule

>>> sv/sdmct_checker.sv
`include "split_direct_mapped_cache_tags_defines.svh"

module sdmct_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic                          rsp_hit,
  input logic [sdmct_pkg::CNT_W-1:0]   access_count,
  input logic [sdmct_pkg::CNT_W-1:0]   hit_count,
  input logic [sdmct_pkg::CNT_W-1:0]   miss_count,
  input logic [sdmct_pkg::RATIO_W-1:0] miss_ratio_q16
);

  localparam logic [sdmct_pkg::RATIO_W-1:0] RATIO_ONE = 17'h10000;

  // a result is held until taken
  `SDMCT_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)

  // one item in the works at a time
  `SDMCT_ASSERT_NEXT(a_one_in_flight, clk, rst, req_valid && req_ready, !req_ready)

  `SDMCT_ASSERT_NOW(a_ratio_range, clk, rst, rsp_valid, miss_ratio_q16 <= RATIO_ONE)

  `SDMCT_ASSERT_NOW(a_count_order, clk, rst, rsp_valid,
                    hit_count <= access_count && miss_count <= access_count)

  `SDMCT_ASSERT_NOW(a_hit_counted, clk, rst, rsp_valid && rsp_hit, hit_count != '0)

endmodule

bind split_direct_mapped_cache_tags sdmct_checker u_sdmct_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_hit        (rsp.hit),
  .access_count   (rsp.access_count),
  .hit_count      (rsp.hit_count),
  .miss_count     (rsp.miss_count),
  .miss_ratio_q16 (rsp.miss_ratio_q16)
);

>>> sim/split_direct_mapped_cache_tags_test.sv
module split_direct_mapped_cache_tags_test;
  import sdmct_pkg::*;

  localparam logic DCACHE = 1'b0;
  localparam logic ICACHE = 1'b1;
  // no register sits at this index; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 4'd12;
  localparam int LINES = 1 << LINE_W;
  localparam int IDLE_PCT = 19;
  localparam int RANDOM_ITEMS = 700;
  localparam int NROWS = 25;

  typedef struct packed {
    logic hit;
    logic [CNT_W-1:0] accesses;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [RATIO_W-1:0] ratio;
    logic [AMAT_W-1:0] amat;
  } outcome_t;

  typedef enum logic {ROW_ACCESS, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    logic instr;
    logic [ADDR_W-1:0] addr;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    logic typed;
    outcome_t want;
  } row_t;

  localparam row_t ROWS [NROWS] = '{
    // cold miss, then hit, then the other cache misses on the same line
    '{ROW_ACCESS, DCACHE, 32'h0000_0000, '0, '0, 1'b1,
      '{1'b0, 32'd1, 32'd0, 32'd1, 17'd65536, 25'd25856}},
    '{ROW_ACCESS, DCACHE, 32'h0000_0000, '0, '0, 1'b1,
      '{1'b1, 32'd2, 32'd1, 32'd1, 17'd32768, 25'd13056}},
    '{ROW_ACCESS, ICACHE, 32'h0000_0000, '0, '0, 1'b1,
      '{1'b0, 32'd3, 32'd1, 32'd2, 17'd43690, 25'd17322}},
    '{ROW_ACCESS, ICACHE, 32'h0000_000F, '0, '0, 1'b1,
      '{1'b1, 32'd4, 32'd2, 32'd2, 17'd32768, 25'd13056}},
    '{ROW_ACCESS, DCACHE, 32'hFFFF_FFFF, '0, '0, 1'b0, '0},
    '{ROW_ACCESS, ICACHE, 32'hFFFF_FFFF, '0, '0, 1'b0, '0},
    '{ROW_ACCESS, DCACHE, 32'hFFFF_FFF0, '0, '0, 1'b0, '0},
    '{ROW_ACCESS, DCACHE, 32'h0000_0400, '0, '0, 1'b0, '0},
    '{ROW_ACCESS, DCACHE, 32'h0000_0000, '0, '0, 1'b0, '0},
    // upper data bits are dropped by the narrow registers
    '{ROW_WRITE, DCACHE, '0, REG_INDEX_BITS, 16'hFFF0, 1'b0, '0},
    '{ROW_WRITE, DCACHE, '0, REG_OFFSET_BITS, 16'hFFE0, 1'b0, '0},
    // old lines stay and compare against tags of the new split
    '{ROW_ACCESS, DCACHE, 32'h0000_0000, '0, '0, 1'b0, '0},
    '{ROW_ACCESS, DCACHE, 32'h0000_0001, '0, '0, 1'b0, '0},
    '{ROW_WRITE, DCACHE, '0, REG_INDEX_BITS, 16'h000F, 1'b0, '0},
    '{ROW_WRITE, DCACHE, '0, REG_OFFSET_BITS, 16'h001F, 1'b0, '0},
    '{ROW_WRITE, DCACHE, '0, REG_NONE, 16'hFFFF, 1'b0, '0},
    '{ROW_ACCESS, DCACHE, 32'h8000_0000, '0, '0, 1'b0, '0},
    '{ROW_ACCESS, ICACHE, 32'hFFFF_FFFF, '0, '0, 1'b0, '0},
    '{ROW_WRITE, DCACHE, '0, REG_HIT_CYCLES, 16'hFFFF, 1'b0, '0},
    '{ROW_WRITE, DCACHE, '0, REG_MISS_PENALTY, 16'hFFFF, 1'b0, '0},
    '{ROW_ACCESS, ICACHE, 32'hFFFF_FFFF, '0, '0, 1'b0, '0},
    '{ROW_WRITE, DCACHE, '0, REG_INDEX_BITS, 16'd10, 1'b0, '0},
    '{ROW_WRITE, DCACHE, '0, REG_OFFSET_BITS, 16'd16, 1'b0, '0},
    '{ROW_ACCESS, DCACHE, 32'hABCD_1234, '0, '0, 1'b0, '0},
    '{ROW_ACCESS, ICACHE, 32'h5432_EDCB, '0, '0, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  sdmct_req_if req ();
  sdmct_rsp_if rsp ();
  sdmct_cfg_if cfg ();

  logic req_typed;
  outcome_t req_want;
  bit calm;
  int mismatches;
  outcome_t pending_outcomes [$];

  bit line_valid [2][LINES];
  bit [TAG_W-1:0] line_tag [2][LINES];
  bit [CNT_W-1:0] seen_accesses;
  bit [CNT_W-1:0] seen_hits;
  bit [CNT_W-1:0] seen_misses;
  logic [IDX_W-1:0] idx_bits;
  logic [OFF_W-1:0] off_bits;
  logic [CYC_W-1:0] hit_cyc;
  logic [CYC_W-1:0] penalty;

  split_direct_mapped_cache_tags uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic outcome_t cache_access(input logic instr, input logic [ADDR_W-1:0] addr);
    int unsigned split;
    logic [63:0] wide;
    logic [63:0] sel;
    logic [63:0] line_mask;
    logic [63:0] ratio;
    logic [63:0] amat;
    logic [LINE_W-1:0] line;
    logic [TAG_W-1:0] tag;
    logic found;
    outcome_t o;
    split = idx_bits + off_bits;
    wide = {32'd0, addr};
    line_mask = (64'd1 << idx_bits) - 64'd1;
    sel = (wide >> off_bits) & line_mask;
    // index bits past LINE_W fold away, the tag still starts above them
    line = sel[LINE_W-1:0];
    wide = wide >> split;
    tag = wide[TAG_W-1:0];
    found = line_valid[instr][line] && line_tag[instr][line] == tag;
    if (found) begin
      if (seen_hits != CNT_MAX) seen_hits++;
    end else begin
      if (seen_misses != CNT_MAX) seen_misses++;
      line_valid[instr][line] = 1'b1;
      line_tag[instr][line] = tag;
    end
    if (seen_accesses != CNT_MAX) seen_accesses++;
    ratio = ({32'd0, seen_misses} << 16) / {32'd0, seen_accesses};
    if (ratio > 64'd65536) ratio = 64'd65536;
    amat = ({48'd0, hit_cyc} << 8) + (({48'd0, penalty} * ratio) >> 8);
    o.hit = found;
    o.accesses = seen_accesses;
    o.hits = seen_hits;
    o.misses = seen_misses;
    o.ratio = ratio[RATIO_W-1:0];
    o.amat = amat[AMAT_W-1:0];
    return o;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pad_high(input int unsigned v, input int w);
    logic [CFG_DATA_W-1:0] keep;
    keep = (CFG_DATA_W'(1) << w) - CFG_DATA_W'(1);
    return (CFG_DATA_W'($urandom) & ~keep) | (CFG_DATA_W'(v) & keep);
  endfunction

  task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic send_access(input logic instr, input logic [ADDR_W-1:0] addr,
                             input logic typed, input outcome_t want);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.command <= instr;
    req.address <= addr;
    req_typed <= typed;
    req_want <= want;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_until_idle();
    req.valid <= 1'b0;
    // first let the last accepted transaction reach the queue
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) rsp.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk) begin
    outcome_t exp_o;
    if (rst) begin
      foreach (line_valid[c, l]) begin
        line_valid[c][l] = 1'b0;
        line_tag[c][l] = '0;
      end
      seen_accesses = '0;
      seen_hits = '0;
      seen_misses = '0;
      idx_bits = RST_INDEX_BITS;
      off_bits = RST_OFFSET_BITS;
      hit_cyc = RST_HIT_CYCLES;
      penalty = RST_MISS_PENALTY;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_INDEX_BITS:   idx_bits = cfg.data[IDX_W-1:0];
          REG_OFFSET_BITS:  off_bits = cfg.data[OFF_W-1:0];
          REG_HIT_CYCLES:   hit_cyc = cfg.data[CYC_W-1:0];
          REG_MISS_PENALTY: penalty = cfg.data[CYC_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        exp_o = cache_access(req.command, req.address);
        pending_outcomes.push_back(req_typed ? req_want : exp_o);
      end
      if (rsp.valid && rsp.ready) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t: result with nothing pending: hit=%0b accesses=%0d", $time,
                   rsp.hit, rsp.access_count);
          mismatches++;
        end else begin
          exp_o = pending_outcomes.pop_front();
          check_field("hit", CNT_W'(exp_o.hit), CNT_W'(rsp.hit));
          check_field("access_count", exp_o.accesses, rsp.access_count);
          check_field("hit_count", exp_o.hits, rsp.hit_count);
          check_field("miss_count", exp_o.misses, rsp.miss_count);
          check_field("miss_ratio_q16", CNT_W'(exp_o.ratio), CNT_W'(rsp.miss_ratio_q16));
          check_field("amat_q8", CNT_W'(exp_o.amat), CNT_W'(rsp.amat_q8));
        end
      end
    end
  end

  initial begin
    row_t r;
    logic [ADDR_W:0] recent [$];
    logic [ADDR_W:0] ent;
    logic [63:0] span;
    int unsigned shift;
    int unsigned v;
    int sent;
    int phase;
    int n;
    int pick;
    req.valid = 1'b0;
    req.command = DCACHE;
    req.address = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_INDEX_BITS;
    cfg.data = '0;
    rsp.ready = 1'b0;
    req_typed = 1'b0;
    req_want = '0;
    calm = 1'b0;
    mismatches = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NROWS; i++) begin
      r = ROWS[i];
      if (r.kind == ROW_WRITE) begin
        wait_until_idle();
        write_reg(r.reg_idx, r.reg_data);
      end else begin
        send_access(r.instr, r.addr, r.typed, r.want);
      end
    end

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_until_idle();
      calm = (phase == 3 || phase == 4);
      pick = $urandom_range(5);
      v = (pick == 0) ? 0 : (pick == 1) ? 10 : (pick == 2) ? 15 : $urandom_range(1, 8);
      write_reg(REG_INDEX_BITS, pad_high(v, IDX_W));
      pick = $urandom_range(5);
      v = (pick == 0) ? 0 : (pick == 1) ? 16 : (pick == 2) ? 31 : $urandom_range(0, 8);
      write_reg(REG_OFFSET_BITS, pad_high(v, OFF_W));
      pick = $urandom_range(5);
      v = (pick == 0) ? 0 : (pick == 1) ? 65535 :
          (pick == 2) ? $urandom_range(65535) : $urandom_range(1, 200);
      write_reg(REG_HIT_CYCLES, CFG_DATA_W'(v));
      pick = $urandom_range(5);
      v = (pick == 0) ? 0 : (pick == 1) ? 65535 :
          (pick == 2) ? $urandom_range(65535) : $urandom_range(1, 200);
      write_reg(REG_MISS_PENALTY, CFG_DATA_W'(v));

      n = $urandom_range(40, 90);
      for (int k = 0; k < n; k++) begin
        pick = $urandom_range(99);
        ent = {1'($urandom), ADDR_W'($urandom)};
        if (recent.size() != 0 && pick < 65) begin
          ent = recent[$urandom_range(recent.size() - 1)];
          span = (64'd1 << off_bits) - 64'd1;
          if (pick < 20) begin
            // same line, other byte
            ent[ADDR_W-1:0] ^= span[ADDR_W-1:0] & ADDR_W'($urandom);
          end else if (pick < 35) begin
            // same line, other tag
            shift = idx_bits + off_bits;
            if (shift < ADDR_W) ent[ADDR_W-1:0] += ADDR_W'($urandom_range(1, 3)) << shift;
          end else if (pick < 40) begin
            ent[ADDR_W] = ~ent[ADDR_W];
          end
        end else if (pick > 95) begin
          ent[ADDR_W-1:0] = {ADDR_W{pick[0]}};
        end
        recent.push_back(ent);
        if (recent.size() > 16) void'(recent.pop_front());
        send_access(ent[ADDR_W], ent[ADDR_W-1:0], 1'b0, '0);
        sent++;
      end
      phase++;
    end

    wait_until_idle();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/sdmct_pkg.sv
sv/sdmct_ifs.sv
sv/sdmct_tag_ram.sv
sv/sdmct_ctrl.sv
sv/sdmct_dp.sv
sv/split_direct_mapped_cache_tags.sv
sv/sdmct_checker.sv
sim/split_direct_mapped_cache_tags_test.sv
